// ----- rtl/u8rx_pkg.sv -----
// ----------------------------------------------------------------------------
// u8rx_pkg - shared types and constants for the 8N1 UART with receive ring
// Transaction payload structs, state encodings, register indexes, resets.
// ----------------------------------------------------------------------------
package u8rx_pkg;

	localparam int unsigned BIT_PERIOD_W   = 16;
	localparam int unsigned TX_GUARD_W     = 4;
	localparam int unsigned TX_TIMER_W     = 20;
	localparam int unsigned BIT_INDEX_W    = 4;
	localparam int unsigned RX_COUNT_W     = 6;
	localparam int unsigned CFG_INDEX_W    = 1;
	localparam int unsigned CFG_DATA_W     = 16;
	localparam int unsigned RING_DEPTH_DEF = 64;

	localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RST = 16'd7;
	localparam logic [TX_GUARD_W-1:0]   TX_GUARD_RST   = 4'd8;
	localparam logic [BIT_INDEX_W-1:0]  BITS_PER_BYTE  = 4'd8;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TX_GUARD   = 1'b1;

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_HALF,
		RX_DATA,
		RX_STOP
	} rx_state_t;

	typedef enum logic [1:0] {
		TX_IDLE,
		TX_DATA,
		TX_STOP,
		TX_GUARD
	} tx_state_t;

	typedef struct packed {
		logic       rx_level;
		logic       read_req;
		logic       write_req;
		logic [7:0] tx_byte;
		logic       flush_req;
	} in_item_t;

	typedef struct packed {
		logic                  tx_level;
		logic                  read_valid;
		logic [7:0]            read_data;
		logic [RX_COUNT_W-1:0] rx_count;
		logic                  overflow;
		logic                  tx_busy;
		logic                  write_accepted;
	} out_item_t;

	// requests from the tick logic into the receive ring
	typedef struct packed {
		logic advance;
		logic pop;
		logic push;
		logic flush;
	} ring_ctl_t;

	// ring status for the tick being processed
	typedef struct packed {
		logic pop_valid;
		logic overflow;
	} ring_sts_t;

endpackage

// ----- rtl/u8rx_ring.sv -----
// ----------------------------------------------------------------------------
// u8rx_ring - receive byte ring, one slot kept free
// Pop sees the ring before this tick's push; flush clears pointers and flag.
// ----------------------------------------------------------------------------
module u8rx_ring #(
	parameter int unsigned RING_DEPTH = u8rx_pkg::RING_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  u8rx_pkg::ring_ctl_t                  ctl,
	input  logic [7:0]                           push_data,
	output u8rx_pkg::ring_sts_t                  sts,
	output logic [7:0]                           pop_data,
	output logic [u8rx_pkg::RX_COUNT_W-1:0]      count
);

	localparam int unsigned PW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned CNT_W = u8rx_pkg::RX_COUNT_W;
	localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);

	logic [7:0]    mem [RING_DEPTH];
	logic [PW-1:0] head_q, tail_q, head_n, tail_n;
	logic          ovf_q, ovf_n;
	logic          pop, wr_en;
	logic [PW-1:0] tail_inc;
	logic [7:0]    head_data_q;
	logic [PW:0]   used;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		ovf_n    = ovf_q;
		pop      = 1'b0;
		wr_en    = 1'b0;
		tail_inc = ptr_inc(tail_q);
		if (ctl.advance) begin
			if (ctl.flush) begin
				head_n = '0;
				tail_n = '0;
				ovf_n  = 1'b0;
			end else begin
				if (ctl.pop && head_q != tail_q) begin
					pop    = 1'b1;
					head_n = ptr_inc(head_q);
				end
				if (ctl.push) begin
					if (tail_inc != head_n) begin
						wr_en  = 1'b1;
						tail_n = tail_inc;
					end else begin
						ovf_n = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			head_q <= head_n;
			tail_q <= tail_n;
			ovf_q  <= ovf_n;
		end
	end

	// head entry is kept prefetched; a write landing on the new head is forwarded
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= push_data;
		end
		head_data_q <= (wr_en && tail_q == head_n) ? push_data : mem[head_n];
	end

	always_comb begin
		if (tail_n >= head_n) begin
			used = {1'b0, tail_n} - {1'b0, head_n};
		end else begin
			used = {1'b0, tail_n} + (PW+1)'(RING_DEPTH) - {1'b0, head_n};
		end
	end

	assign count         = CNT_W'(used);
	assign sts.pop_valid = pop;
	assign sts.overflow  = ovf_n;
	assign pop_data      = pop ? head_data_q : 8'h00;

endmodule

// ----- rtl/uart_8n1_with_rx_ring.sv -----
// ----------------------------------------------------------------------------
// uart_8n1_with_rx_ring - tick-driven 8N1 UART transceiver with receive ring
// Receiver, transmitter and host requests advanced once per input transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one time tick: the sampled receive line plus the
// host's read, write and flush requests. Each accepted tick produces exactly
// one registered output transaction, holding the transmit line, the
// popped byte, the ring fill count, the sticky overflow flag and transmitter
// status as they stand after that tick. A new tick is accepted every cycle
// while the output register is empty or being drained, so the sustained rate
// is one tick per clock; the single output register sets that figure, and
// in_stall rises only while a finished result sits unclaimed under out_stall.
// The receiver samples data LSB first at 1.5, 2.5, ... bit periods after the
// start tick and does not check the stop bit. The ring keeps one slot free,
// so it holds RING_DEPTH-1 bytes; its memory has one write and one read port,
// and the head entry is prefetched (with write forwarding) so a pop returns
// data in the same tick. Ring contents are not cleared at reset; only
// written entries are ever read. Program bit_period and tx_guard_bits only
// while no tick is outstanding.
module uart_8n1_with_rx_ring #(
	parameter int unsigned RING_DEPTH = u8rx_pkg::RING_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [u8rx_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [u8rx_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  u8rx_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output u8rx_pkg::out_item_t                 out_data
);

	localparam int unsigned BPW = u8rx_pkg::BIT_PERIOD_W;
	localparam int unsigned TGW = u8rx_pkg::TX_GUARD_W;
	localparam int unsigned TTW = u8rx_pkg::TX_TIMER_W;
	localparam int unsigned BIW = u8rx_pkg::BIT_INDEX_W;
	localparam int unsigned CNW = u8rx_pkg::RX_COUNT_W;

	// configuration
	logic [BPW-1:0] bit_period_q;
	logic [TGW-1:0] tx_guard_q;

	// receiver
	u8rx_pkg::rx_state_t rx_state_q, rx_state_n;
	logic [BPW-1:0]      rx_timer_q, rx_timer_n;
	logic [BIW-1:0]      rx_idx_q, rx_idx_n;
	logic [7:0]          rx_shift_q, rx_shift_n;
	logic                rx_got;

	// transmitter
	u8rx_pkg::tx_state_t tx_state_q, tx_state_n;
	logic [TTW-1:0]      tx_timer_q, tx_timer_n;
	logic [BIW-1:0]      tx_idx_q, tx_idx_n;
	logic [7:0]          tx_shift_q, tx_shift_n;
	logic                tx_line_q, tx_line_n;
	logic                tx_accept;
	logic [TTW-1:0]      guard_ticks;

	// ring
	u8rx_pkg::ring_ctl_t ring_ctl;
	u8rx_pkg::ring_sts_t ring_sts;
	logic [7:0]          pop_data;
	logic [CNW-1:0]      ring_count;

	logic accept;

	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	// -- configuration registers --------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= u8rx_pkg::BIT_PERIOD_RST;
			tx_guard_q   <= u8rx_pkg::TX_GUARD_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				u8rx_pkg::CFG_BIT_PERIOD: bit_period_q <= BPW'(cfg_data);
				u8rx_pkg::CFG_TX_GUARD:   tx_guard_q   <= TGW'(cfg_data);
				default: ;
			endcase
		end
	end

	// -- receiver: start detect, half-bit wait, eight samples, stop wait -----
	always_comb begin
		rx_state_n = rx_state_q;
		rx_timer_n = rx_timer_q;
		rx_idx_n   = rx_idx_q;
		rx_shift_n = rx_shift_q;
		rx_got     = 1'b0;
		if (rx_state_q == u8rx_pkg::RX_IDLE) begin
			if (!in_data.rx_level) begin
				rx_state_n = u8rx_pkg::RX_HALF;
				rx_timer_n = bit_period_q >> 1;
				rx_idx_n   = '0;
				rx_shift_n = '0;
			end
		end else if (rx_timer_q > BPW'(1)) begin
			rx_timer_n = rx_timer_q - 1'b1;
		end else begin
			case (rx_state_q)
				u8rx_pkg::RX_HALF: begin
					rx_state_n = u8rx_pkg::RX_DATA;
					rx_timer_n = bit_period_q;
				end
				u8rx_pkg::RX_DATA: begin
					rx_shift_n = {in_data.rx_level, rx_shift_q[7:1]};
					rx_idx_n   = rx_idx_q + 1'b1;
					rx_timer_n = bit_period_q;
					if (rx_idx_n >= u8rx_pkg::BITS_PER_BYTE) begin
						rx_got     = 1'b1;
						rx_state_n = u8rx_pkg::RX_STOP;
					end
				end
				default: begin
					rx_state_n = u8rx_pkg::RX_IDLE;
					rx_timer_n = '0;
				end
			endcase
		end
	end

	// -- transmitter: data bits, stop, guard idle, then take a new byte ------
	assign guard_ticks = TTW'(tx_guard_q) * TTW'(bit_period_q);

	always_comb begin
		tx_state_n = tx_state_q;
		tx_timer_n = tx_timer_q;
		tx_idx_n   = tx_idx_q;
		tx_shift_n = tx_shift_q;
		tx_line_n  = tx_line_q;
		tx_accept  = 1'b0;
		if (tx_state_q != u8rx_pkg::TX_IDLE) begin
			if (tx_timer_q > TTW'(1)) begin
				tx_timer_n = tx_timer_q - 1'b1;
			end else begin
				case (tx_state_q)
					u8rx_pkg::TX_DATA: begin
						tx_timer_n = TTW'(bit_period_q);
						if (tx_idx_q < u8rx_pkg::BITS_PER_BYTE) begin
							tx_line_n  = tx_shift_q[0];
							tx_shift_n = tx_shift_q >> 1;
							tx_idx_n   = tx_idx_q + 1'b1;
						end else begin
							tx_line_n  = 1'b1;
							tx_state_n = u8rx_pkg::TX_STOP;
						end
					end
					u8rx_pkg::TX_STOP: begin
						if (tx_guard_q != '0) begin
							tx_state_n = u8rx_pkg::TX_GUARD;
							tx_timer_n = guard_ticks;
						end else begin
							tx_state_n = u8rx_pkg::TX_IDLE;
							tx_timer_n = '0;
						end
					end
					default: begin
						tx_state_n = u8rx_pkg::TX_IDLE;
						tx_timer_n = '0;
					end
				endcase
			end
		end
		// a write is taken on the very tick the line goes idle
		if (in_data.write_req && tx_state_n == u8rx_pkg::TX_IDLE) begin
			tx_state_n = u8rx_pkg::TX_DATA;
			tx_shift_n = in_data.tx_byte;
			tx_idx_n   = '0;
			tx_line_n  = 1'b0;
			tx_timer_n = TTW'(bit_period_q);
			tx_accept  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_state_q <= u8rx_pkg::RX_IDLE;
			rx_timer_q <= '0;
			rx_idx_q   <= '0;
			rx_shift_q <= '0;
			tx_state_q <= u8rx_pkg::TX_IDLE;
			tx_timer_q <= '0;
			tx_idx_q   <= '0;
			tx_shift_q <= '0;
			tx_line_q  <= 1'b1;
		end else if (accept) begin
			rx_state_q <= rx_state_n;
			rx_timer_q <= rx_timer_n;
			rx_idx_q   <= rx_idx_n;
			rx_shift_q <= rx_shift_n;
			tx_state_q <= tx_state_n;
			tx_timer_q <= tx_timer_n;
			tx_idx_q   <= tx_idx_n;
			tx_shift_q <= tx_shift_n;
			tx_line_q  <= tx_line_n;
		end
	end

	// -- receive ring ---------------------------------------------------------
	assign ring_ctl.advance = accept;
	assign ring_ctl.pop     = in_data.read_req;
	assign ring_ctl.push    = rx_got;
	assign ring_ctl.flush   = in_data.flush_req;

	u8rx_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ring_ctl),
		.push_data (rx_shift_n),
		.sts       (ring_sts),
		.pop_data  (pop_data),
		.count     (ring_count)
	);

	// -- output register --------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data.tx_level       <= tx_line_n;
			out_data.read_valid     <= ring_sts.pop_valid;
			out_data.read_data      <= pop_data;
			out_data.rx_count       <= ring_count;
			out_data.overflow       <= ring_sts.overflow;
			out_data.tx_busy        <= (tx_state_n != u8rx_pkg::TX_IDLE);
			out_data.write_accepted <= tx_accept;
		end
	end

endmodule

// ----- rtl/u8rx_checker.sv -----
// ----------------------------------------------------------------------------
// u8rx_checker - port-level checks for the 8N1 UART with receive ring
// Watches output transactions and the stall path; bound to the top level.
// ----------------------------------------------------------------------------
module u8rx_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input u8rx_pkg::out_item_t   out_data
);

	// input is held off only by an unclaimed result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a pending output transaction");

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled output transaction changed");

	// no byte is reported unless a pop happened
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.read_valid) |-> (out_data.read_data == 8'h00))
		else $error("read_data nonzero without read_valid");

	// a frame starts with the start bit on the line
	a_tx_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.write_accepted) |-> (!out_data.tx_level && out_data.tx_busy))
		else $error("accepted write without start bit");

	// an idle transmitter holds the line high
	a_tx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.tx_busy) |-> out_data.tx_level)
		else $error("idle transmitter drives line low");

endmodule

bind uart_8n1_with_rx_ring u8rx_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
